// ----- rtl/olid_pkg.sv -----
// olid_pkg: shared types, codes and sizes of the ordered list block
// used by the interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps

package olid_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int COUNT_W    = $clog2(CAPACITY + 1);
	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_READ   = 3'd1,
		CMD_UPDATE = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_DELETE = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_READ,
		OP_UPDATE,
		OP_INSERT,
		OP_DELETE
	} dp_op_t;

	typedef enum logic {
		RES_EMPTY,
		RES_HELD
	} ctrl_state_t;

	typedef struct packed {
		logic                  load;
		dp_op_t                op;
		logic [IDX_W-1:0]      idx;
		logic [DATA_WIDTH-1:0] word;
	} dp_cmd_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
	} dp_stat_t;

endpackage

// ----- rtl/olid_if.sv -----
// olid_in_if and olid_out_if: valid/ready channels of the ordered list block
// depends on olid_pkg for field widths
`timescale 1ns / 1ps

interface olid_in_if;
	logic                              valid;
	logic                              ready;
	logic [olid_pkg::CMD_W-1:0]        command;
	logic [olid_pkg::IDX_W-1:0]        position;
	logic [olid_pkg::DATA_WIDTH-1:0]   word_in;

	modport source (output valid, command, position, word_in, input ready);
	modport sink (input valid, command, position, word_in, output ready);
endinterface

interface olid_out_if;
	logic                              valid;
	logic                              ready;
	logic [olid_pkg::STATUS_W-1:0]     status;
	logic [olid_pkg::DATA_WIDTH-1:0]   word_out;
	logic [olid_pkg::COUNT_W-1:0]      entry_count;

	modport source (output valid, status, word_out, entry_count, input ready);
	modport sink (input valid, status, word_out, entry_count, output ready);
endinterface

// ----- rtl/olid_dp.sv -----
// olid_dp: row of entry cells with shift up/down, count and result registers
// depends on olid_pkg
`timescale 1ns / 1ps

module olid_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  olid_pkg::dp_cmd_t  cmd,
	output olid_pkg::dp_stat_t stat,
	output logic [olid_pkg::DATA_WIDTH-1:0] word_out
);

	logic [olid_pkg::DATA_WIDTH-1:0] entries_q [olid_pkg::CAPACITY];
	logic [olid_pkg::COUNT_W-1:0]    count_q;
	logic [olid_pkg::DATA_WIDTH-1:0] word_q;

	// each cell picks its own next value
	for (genvar i = 0; i < olid_pkg::CAPACITY; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.load) begin
				case (cmd.op)
					olid_pkg::OP_UPDATE: begin
						if (cmd.idx == olid_pkg::IDX_W'(i))
							entries_q[i] <= cmd.word;
					end
					olid_pkg::OP_INSERT: begin
						if (cmd.idx == olid_pkg::IDX_W'(i))
							entries_q[i] <= cmd.word;
						else if (i > 0 && cmd.idx < olid_pkg::IDX_W'(i))
							entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
					end
					olid_pkg::OP_DELETE: begin
						if (i < olid_pkg::CAPACITY - 1 && cmd.idx <= olid_pkg::IDX_W'(i))
							entries_q[i] <= entries_q[(i < olid_pkg::CAPACITY - 1) ? i + 1 : i];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			case (cmd.op)
				olid_pkg::OP_INSERT: count_q <= count_q + 1'b1;
				olid_pkg::OP_DELETE: count_q <= count_q - 1'b1;
				default:             count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			word_q <= (cmd.op == olid_pkg::OP_READ) ? entries_q[cmd.idx] : '0;
	end

	assign stat.count = count_q;
	assign word_out   = word_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= olid_pkg::COUNT_W'(olid_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && cmd.op == olid_pkg::OP_INSERT
		|=> count_q == olid_pkg::COUNT_W'($past(count_q) + 1'b1))
		else $error("insert did not grow the list");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && cmd.op == olid_pkg::OP_DELETE
		|=> count_q == olid_pkg::COUNT_W'($past(count_q) - 1'b1))
		else $error("delete did not shrink the list");

	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && cmd.op != olid_pkg::OP_READ |=> word_q == '0)
		else $error("word out not zero for a non-read transaction");
`endif

endmodule

// ----- rtl/olid_ctrl.sv -----
// olid_ctrl: range and capacity checks, datapath commands, result handshake
// depends on olid_pkg and the channel interfaces
`timescale 1ns / 1ps

module olid_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	olid_in_if.sink              cmd_ch,
	input  logic                 res_ready,
	output logic                 res_valid,
	output logic [olid_pkg::STATUS_W-1:0] status,
	input  olid_pkg::dp_stat_t   stat,
	output olid_pkg::dp_cmd_t    cmd
);

	olid_pkg::ctrl_state_t state_q, state_d;
	olid_pkg::status_t     status_q, status_d;
	logic                  take;
	logic [olid_pkg::COUNT_W-1:0] pos_ext;
	logic                  full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olid_pkg::RES_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			status_q <= status_d;
	end

	always_comb begin
		pos_ext      = olid_pkg::COUNT_W'(cmd_ch.position);
		full         = stat.count == olid_pkg::COUNT_W'(olid_pkg::CAPACITY);
		cmd_ch.ready = (state_q == olid_pkg::RES_EMPTY) || res_ready;
		take         = cmd_ch.valid && cmd_ch.ready;
		status_d     = olid_pkg::ST_OK;
		cmd.load     = take;
		cmd.op       = olid_pkg::OP_NONE;
		cmd.idx      = cmd_ch.position;
		cmd.word     = cmd_ch.word_in;

		case (cmd_ch.command)
			olid_pkg::CMD_APPEND: begin
				if (full) begin
					status_d = olid_pkg::ST_FULL;
				end else begin
					cmd.op  = olid_pkg::OP_INSERT;
					cmd.idx = stat.count[olid_pkg::IDX_W-1:0];
				end
			end
			olid_pkg::CMD_READ: begin
				if (pos_ext >= stat.count) status_d = olid_pkg::ST_BAD_INDEX;
				else cmd.op = olid_pkg::OP_READ;
			end
			olid_pkg::CMD_UPDATE: begin
				if (pos_ext >= stat.count) status_d = olid_pkg::ST_BAD_INDEX;
				else cmd.op = olid_pkg::OP_UPDATE;
			end
			olid_pkg::CMD_INSERT: begin
				if (pos_ext > stat.count) status_d = olid_pkg::ST_BAD_INDEX;
				else if (full) status_d = olid_pkg::ST_FULL;
				else cmd.op = olid_pkg::OP_INSERT;
			end
			olid_pkg::CMD_DELETE: begin
				if (pos_ext >= stat.count) status_d = olid_pkg::ST_BAD_INDEX;
				else cmd.op = olid_pkg::OP_DELETE;
			end
			default: begin
			end
		endcase

		case (state_q)
			olid_pkg::RES_EMPTY: state_d = take ? olid_pkg::RES_HELD : olid_pkg::RES_EMPTY;
			olid_pkg::RES_HELD: begin
				if (take) state_d = olid_pkg::RES_HELD;
				else if (res_ready) state_d = olid_pkg::RES_EMPTY;
				else state_d = olid_pkg::RES_HELD;
			end
			default: state_d = olid_pkg::RES_EMPTY;
		endcase
	end

	assign res_valid = state_q == olid_pkg::RES_HELD;
	assign status    = status_q;

endmodule

// ----- rtl/ordered_list_insert_delete.sv -----
// ordered_list_insert_delete: top level joining controller and datapath
// depends on olid_pkg, olid_in_if, olid_out_if, olid_ctrl and olid_dp
`timescale 1ns / 1ps

// Ordered list of up to 16 words of 32 bits with append, read, update,
// positional insert and positional delete. Each command transaction gives one
// result transaction carrying a status (ok, index out of range, list full), the
// word read (zero unless a read succeeds) and the entry count after the
// command. A command is taken and its result appears in the output register
// on the next cycle; a new command is accepted in the same cycle the held
// result is taken, so one command per cycle is sustained while the receiver
// takes each result. This rate rests on the row of entry cells, which shift
// all entries at once. Entries need no clearing after reset; only positions
// below the count are ever read.

module ordered_list_insert_delete (
	input logic      clk,
	input logic      arst_n,
	olid_in_if.sink  cmd_ch,
	olid_out_if.source res_ch
);

	olid_pkg::dp_cmd_t  dp_cmd;
	olid_pkg::dp_stat_t dp_stat;

	olid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.res_ready (res_ch.ready),
		.res_valid (res_ch.valid),
		.status    (res_ch.status),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	olid_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dp_cmd),
		.stat     (dp_stat),
		.word_out (res_ch.word_out)
	);

	assign res_ch.entry_count = dp_stat.count;

endmodule

// ----- verif/tb_ordered_list_insert_delete.sv -----
// tb_ordered_list_insert_delete: self-checking testbench of the ordered list block
// depends on olid_pkg, olid_in_if, olid_out_if and ordered_list_insert_delete
// a list model predicts each result; directed then random commands under varying idling
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [olid_pkg::CMD_W-1:0] CMD_NOP_LO =
		olid_pkg::CMD_W'(olid_pkg::CMD_DELETE + 1);
	localparam logic [olid_pkg::CMD_W-1:0] CMD_NOP_HI = '1;

	typedef struct packed {
		logic [olid_pkg::CMD_W-1:0]      code;
		logic [olid_pkg::IDX_W-1:0]      pos;
		logic [olid_pkg::DATA_WIDTH-1:0] word;
	} list_cmd_t;

	typedef struct packed {
		logic [olid_pkg::STATUS_W-1:0]   status;
		logic [olid_pkg::DATA_WIDTH-1:0] word;
		logic [olid_pkg::COUNT_W-1:0]    count;
	} list_result_t;

	logic clk;
	logic arst_n;

	olid_in_if  cmd_ch ();
	olid_out_if res_ch ();

	ordered_list_insert_delete dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	list_cmd_t    pending_cmds[$];
	list_result_t expected_results[$];

	logic [olid_pkg::DATA_WIDTH-1:0] list_words [olid_pkg::CAPACITY];
	logic [olid_pkg::COUNT_W-1:0]    list_len = '0;
	logic [olid_pkg::COUNT_W-1:0]    gen_len = '0;

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  hold_len = 0;
	int  held = 0;
	bit  offering = 0;
	int  mismatches = 0;
	int  cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic list_result_t apply_command(list_cmd_t c);
		list_result_t r;
		int i;
		r.status = olid_pkg::ST_OK;
		r.word = '0;
		case (c.code)
			olid_pkg::CMD_APPEND: begin
				if (list_len >= olid_pkg::CAPACITY) begin
					r.status = olid_pkg::ST_FULL;
				end else begin
					list_words[list_len[olid_pkg::IDX_W-1:0]] = c.word;
					list_len++;
				end
			end
			olid_pkg::CMD_READ: begin
				if (c.pos >= list_len) r.status = olid_pkg::ST_BAD_INDEX;
				else r.word = list_words[c.pos];
			end
			olid_pkg::CMD_UPDATE: begin
				if (c.pos >= list_len) r.status = olid_pkg::ST_BAD_INDEX;
				else list_words[c.pos] = c.word;
			end
			olid_pkg::CMD_INSERT: begin
				if (c.pos > list_len) begin
					r.status = olid_pkg::ST_BAD_INDEX;
				end else if (list_len >= olid_pkg::CAPACITY) begin
					r.status = olid_pkg::ST_FULL;
				end else begin
					for (i = int'(list_len); i > int'(c.pos); i--)
						list_words[olid_pkg::IDX_W'(i)] = list_words[olid_pkg::IDX_W'(i-1)];
					list_words[c.pos] = c.word;
					list_len++;
				end
			end
			olid_pkg::CMD_DELETE: begin
				if (c.pos >= list_len) begin
					r.status = olid_pkg::ST_BAD_INDEX;
				end else begin
					for (i = int'(c.pos); i + 1 < int'(list_len); i++)
						list_words[olid_pkg::IDX_W'(i)] = list_words[olid_pkg::IDX_W'(i+1)];
					list_len--;
				end
			end
			default: ;
		endcase
		r.count = list_len;
		return r;
	endfunction

	// entry count the generator expects after a command, used to steer positions
	function automatic logic [olid_pkg::COUNT_W-1:0] len_after(list_cmd_t c,
			logic [olid_pkg::COUNT_W-1:0] n);
		case (c.code)
			olid_pkg::CMD_APPEND: return (n < olid_pkg::CAPACITY) ? n + 1'b1 : n;
			olid_pkg::CMD_INSERT:
				return (c.pos <= n && n < olid_pkg::CAPACITY) ? n + 1'b1 : n;
			olid_pkg::CMD_DELETE: return (c.pos < n) ? n - 1'b1 : n;
			default:    return n;
		endcase
	endfunction

	task automatic queue_cmd(logic [olid_pkg::CMD_W-1:0] code,
			logic [olid_pkg::IDX_W-1:0] pos, logic [olid_pkg::DATA_WIDTH-1:0] word);
		list_cmd_t c;
		c.code = code;
		c.pos = pos;
		c.word = word;
		pending_cmds.push_back(c);
		gen_len = len_after(c, gen_len);
	endtask

	task automatic queue_random(int n);
		bit growing;
		int r;
		int top;
		logic [olid_pkg::CMD_W-1:0] code;
		logic [olid_pkg::IDX_W-1:0] pos;
		logic [olid_pkg::DATA_WIDTH-1:0] word;
		growing = 1'b1;
		for (int k = 0; k < n; k++) begin
			if (k % 64 == 63) growing = !growing;
			r = int'($urandom_range(99));
			if (growing) begin
				if (r < 40) code = olid_pkg::CMD_APPEND;
				else if (r < 55) code = olid_pkg::CMD_INSERT;
				else if (r < 70) code = olid_pkg::CMD_READ;
				else if (r < 85) code = olid_pkg::CMD_UPDATE;
				else if (r < 93) code = olid_pkg::CMD_DELETE;
				else code = olid_pkg::CMD_W'($urandom_range(CMD_NOP_HI, CMD_NOP_LO));
			end else begin
				if (r < 10) code = olid_pkg::CMD_APPEND;
				else if (r < 20) code = olid_pkg::CMD_INSERT;
				else if (r < 35) code = olid_pkg::CMD_READ;
				else if (r < 50) code = olid_pkg::CMD_UPDATE;
				else if (r < 95) code = olid_pkg::CMD_DELETE;
				else code = olid_pkg::CMD_W'($urandom_range(CMD_NOP_HI, CMD_NOP_LO));
			end
			top = (gen_len > olid_pkg::CAPACITY - 1) ? olid_pkg::CAPACITY - 1 : int'(gen_len);
			if ($urandom_range(9) < 8) pos = olid_pkg::IDX_W'($urandom_range(top, 0));
			else pos = olid_pkg::IDX_W'($urandom_range(olid_pkg::CAPACITY - 1, 0));
			case ($urandom_range(9))
				0: word = '0;
				1: word = '1;
				default: word = $urandom;
			endcase
			queue_cmd(code, pos, word);
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!offering) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd_ch.valid    <= 1'b1;
				cmd_ch.command  <= pending_cmds[0].code;
				cmd_ch.position <= pending_cmds[0].pos;
				cmd_ch.word_in  <= pending_cmds[0].word;
				offering = 1'b1;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// receiver, with an optional long hold-off first
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (held < hold_len) begin
			held++;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: predict on each command transaction, check each result transaction
	always @(posedge clk) begin
		list_cmd_t c;
		list_result_t e;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				c.code = cmd_ch.command;
				c.pos = cmd_ch.position;
				c.word = cmd_ch.word_in;
				expected_results.push_back(apply_command(c));
				void'(pending_cmds.pop_front());
				offering = 1'b0;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no command outstanding");
					mismatches++;
				end else begin
					e = expected_results.pop_front();
					if (res_ch.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, res_ch.status);
						mismatches++;
					end
					if (res_ch.word_out !== e.word) begin
						$error("word_out: expected %h, got %h", e.word, res_ch.word_out);
						mismatches++;
					end
					if (res_ch.entry_count !== e.count) begin
						$error("entry_count: expected %0d, got %0d", e.count,
							res_ch.entry_count);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = '0;
		cmd_ch.position = '0;
		cmd_ch.word_in = '0;
		res_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 17;
		recv_idle_pct = 80;
		// empty list: read, delete, update and insert past the count are out of range
		queue_cmd(olid_pkg::CMD_READ, 4'd0, 32'h1234_5678);
		queue_cmd(olid_pkg::CMD_DELETE, 4'd0, '0);
		queue_cmd(olid_pkg::CMD_UPDATE, 4'd0, '1);
		queue_cmd(olid_pkg::CMD_INSERT, 4'd1, '1);
		queue_cmd(olid_pkg::CMD_INSERT, 4'd0, '1);
		queue_cmd(olid_pkg::CMD_APPEND, 4'hF, '0);
		// insert at the count acts as an append
		queue_cmd(olid_pkg::CMD_INSERT, 4'd2, 32'hA5A5_5A5A);
		queue_cmd(olid_pkg::CMD_INSERT, 4'd1, 32'h8000_0001);
		queue_cmd(olid_pkg::CMD_READ, 4'd0, '0);
		queue_cmd(olid_pkg::CMD_READ, 4'd1, '0);
		queue_cmd(olid_pkg::CMD_READ, 4'd2, '0);
		queue_cmd(olid_pkg::CMD_READ, 4'd3, '0);
		queue_cmd(olid_pkg::CMD_UPDATE, 4'd3, 32'h0000_FFFF);
		queue_cmd(olid_pkg::CMD_READ, 4'd3, '0);
		queue_cmd(olid_pkg::CMD_DELETE, 4'd1, '0);
		queue_cmd(olid_pkg::CMD_READ, 4'd1, '0);
		queue_cmd(olid_pkg::CMD_DELETE, 4'd2, '0);
		queue_cmd(olid_pkg::CMD_READ, 4'd2, '0);
		queue_cmd(olid_pkg::CMD_READ, 4'hF, '0);
		queue_cmd(CMD_NOP_LO, 4'd0, '1);
		queue_cmd(CMD_NOP_LO + 1'b1, 4'hF, '1);
		queue_cmd(CMD_NOP_HI, 4'd1, '0);
		queue_random(450);
		wait_drained();

		send_idle_pct = 80;
		recv_idle_pct = 17;
		queue_random(450);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_len = 200;
		queue_random(430);
		wait_drained();

		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/olid_pkg.sv
rtl/olid_if.sv
rtl/olid_dp.sv
rtl/olid_ctrl.sv
rtl/ordered_list_insert_delete.sv
verif/tb_ordered_list_insert_delete.sv
